// ===== hdl/ppp_pkg.sv =====
// Shared widths, register codes, reset values and helpers for the perspective point projector.
`timescale 1ns / 1ps
package ppp_pkg;
	localparam int CW = 21;
	localparam int VW = 3 * CW;
	localparam int DW = CW + 1;
	localparam int PRW = CW + DW;
	localparam int SUMW = PRW + 2;
	localparam int UW = SUMW + 1;
	localparam int AAW = 2 * CW;
	localparam int SQW = AAW + 2;
	localparam int TW = SQW + 1;
	localparam int SZW = 12;
	localparam int QW = 24;
	localparam int IDXW = 3;
	localparam int OUT_FRAC_BITS_DEF = 4;
	localparam int MUL_CHUNK = 31;
	localparam int CFG_SETTLE = 6;
	localparam int SETW = 3;

	localparam logic signed [QW-1:0] OUT_MAX = 24'sh7FFFFF;
	localparam logic signed [QW-1:0] OUT_MIN = 24'sh800000;

	localparam logic [VW-1:0] CAM_RST = 63'd0;
	localparam logic [VW-1:0] VIEW_RST = 63'd41;
	localparam logic [VW-1:0] HVEC_RST = 63'd4397725646848;
	localparam logic [VW-1:0] VVEC_RST = 63'd505775348776960;
	localparam logic [SZW-1:0] WIDTH_RST = 12'd800;
	localparam logic [SZW-1:0] HEIGHT_RST = 12'd600;

	typedef enum logic [IDXW-1:0] {
		REG_CAMERA = 3'd0,
		REG_VIEW = 3'd1,
		REG_HVEC = 3'd2,
		REG_VVEC = 3'd3,
		REG_WIDTH = 3'd4,
		REG_HEIGHT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic bad;
		logic hi;
		logic lo;
		logic neg;
	} ax_flag_t;

	// pick component i (x, y, z) of a packed vector register
	function automatic logic signed [CW-1:0] comp(input logic [VW-1:0] v, input int unsigned i);
		comp = v[i * CW +: CW];
	endfunction
endpackage

// ===== hdl/ppp_mul.sv =====
// Three-stage signed multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
module ppp_mul #(
	parameter int AW = 16,
	parameter int BW = 16
) (
	input  logic                    clk,
	input  logic [2:0]              adv,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	localparam int CH = ppp_pkg::MUL_CHUNK;
	localparam int NA = (AW + CH - 1) / CH;
	localparam int NB = (BW + CH - 1) / CH;
	localparam int PW = AW + BW;

	logic signed [NA*CH-1:0] ax;
	logic signed [NB*CH-1:0] bx;
	logic signed [CH:0] ca [NA];
	logic signed [CH:0] cb [NB];
	logic signed [2*CH+1:0] pp_s1 [NA][NB];
	logic signed [PW-1:0] row_s2 [NA];
	logic signed [PW-1:0] row_c [NA];
	logic signed [PW-1:0] p_s3;
	logic signed [PW-1:0] sum_c;

	assign ax = (NA*CH)'(a);
	assign bx = (NB*CH)'(b);

	// lower chunks are unsigned, the top chunk carries the sign
	for (genvar i = 0; i < NA; i++) begin : g_ca
		if (i == NA - 1) begin : g_top
			assign ca[i] = {ax[i*CH+CH-1], ax[i*CH +: CH]};
		end else begin : g_low
			assign ca[i] = {1'b0, ax[i*CH +: CH]};
		end
	end
	for (genvar j = 0; j < NB; j++) begin : g_cb
		if (j == NB - 1) begin : g_top
			assign cb[j] = {bx[j*CH+CH-1], bx[j*CH +: CH]};
		end else begin : g_low
			assign cb[j] = {1'b0, bx[j*CH +: CH]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= ca[i] * cb[j];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (PW'(pp_s1[i][j]) << (CH * j));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			row_s2 <= row_c;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (row_s2[i] << (CH * i));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			p_s3 <= sum_c;
		end
	end

	assign p = p_s3;
endmodule

// ===== hdl/ppp_axis.sv =====
// One screen axis: numerator and denominator products, sign fixup and pipelined divide.
`timescale 1ns / 1ps
module ppp_axis #(
	parameter int PW = 63
) (
	input  logic                            clk,
	input  logic [ppp_pkg::QW+7:0]          adv,
	input  logic signed [ppp_pkg::SUMW-1:0] den,
	input  logic signed [ppp_pkg::UW-1:0]   u,
	input  logic                            bad,
	input  logic signed [PW-1:0]            pvec,
	input  logic signed [PW-1:0]            kn,
	input  logic signed [ppp_pkg::SQW-1:0]  ss,
	output logic signed [ppp_pkg::QW-1:0]   res,
	output logic                            sat
);
	localparam int QW = ppp_pkg::QW;
	localparam int SUMW = ppp_pkg::SUMW;
	localparam int UW = ppp_pkg::UW;
	localparam int SQW = ppp_pkg::SQW;
	localparam int XW = UW + PW + 1;
	localparam int ZW = XW + 1;
	localparam int LW = ZW + QW;

	logic signed [SUMW+PW-1:0] p0;
	logic signed [UW+PW-1:0] p1;
	logic signed [SUMW+SQW-1:0] p2;
	logic bad_s4, bad_s5, bad_s6;

	logic signed [XW-1:0] x_s7, e_s7;
	logic bad_s7;
	logic signed [ZW-1:0] x_s8, e_s8;
	logic bad_s8;
	logic [ZW-1:0] t_s9, e_s9;
	logic neg_s9, bad_s9;

	logic [ZW-1:0] rem_sd [QW+1];
	logic [ZW-1:0] e_sd [QW+1];
	logic [QW-1:0] q_sd [QW+1];
	ppp_pkg::ax_flag_t flg_sd [QW+1];

	logic [QW:0] mag_c, negv_c;
	logic signed [QW-1:0] res_c;
	logic signed [QW-1:0] res_s35;
	logic sat_s35;

	ppp_mul #(.AW(SUMW), .BW(PW)) u_mul_den (
		.clk(clk), .adv(adv[2:0]), .a(den), .b(pvec), .p(p0)
	);
	ppp_mul #(.AW(UW), .BW(PW)) u_mul_num (
		.clk(clk), .adv(adv[2:0]), .a(u), .b(kn), .p(p1)
	);
	ppp_mul #(.AW(SUMW), .BW(SQW)) u_mul_base (
		.clk(clk), .adv(adv[2:0]), .a(den), .b(ss), .p(p2)
	);

	always_ff @(posedge clk) begin
		if (adv[0]) bad_s4 <= bad;
		if (adv[1]) bad_s5 <= bad_s4;
		if (adv[2]) bad_s6 <= bad_s5;
	end

	// numerator and doubled denominator
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			x_s7 <= XW'(p0) + XW'(p1);
			e_s7 <= XW'(p2) <<< 1;
			bad_s7 <= bad_s6;
		end
	end

	// make the denominator positive
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			if (e_s7 < 0) begin
				x_s8 <= -ZW'(x_s7);
				e_s8 <= -ZW'(e_s7);
			end else begin
				x_s8 <= ZW'(x_s7);
				e_s8 <= ZW'(e_s7);
			end
			bad_s8 <= bad_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			neg_s9 <= x_s8 < 0;
			t_s9 <= (x_s8 < 0) ? ZW'(-x_s8) : ZW'(x_s8);
			e_s9 <= ZW'(e_s8);
			bad_s9 <= bad_s8;
		end
	end

	// range check against the quotient width
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			rem_sd[0] <= t_s9;
			e_sd[0] <= e_s9;
			q_sd[0] <= '0;
			flg_sd[0].bad <= bad_s9;
			flg_sd[0].neg <= neg_s9;
			flg_sd[0].hi <= !neg_s9 && (LW'(t_s9) >= (LW'(e_s9) << (QW - 1)));
			flg_sd[0].lo <= neg_s9 && (LW'(t_s9) > (LW'(e_s9) << (QW - 1)));
		end
	end

	// restoring divide, one quotient bit per stage, MSB first
	for (genvar k = 0; k < QW; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv[7+k]) begin
				if (LW'(rem_sd[k]) >= (LW'(e_sd[k]) << (QW - 1 - k))) begin
					rem_sd[k+1] <= rem_sd[k] - ZW'(LW'(e_sd[k]) << (QW - 1 - k));
					q_sd[k+1] <= q_sd[k] | (QW'(1) << (QW - 1 - k));
				end else begin
					rem_sd[k+1] <= rem_sd[k];
					q_sd[k+1] <= q_sd[k];
				end
				e_sd[k+1] <= e_sd[k];
				flg_sd[k+1] <= flg_sd[k];
			end
		end
	end

	// negative values round toward minus infinity
	always_comb begin
		mag_c = {1'b0, q_sd[QW]} + (QW+1)'(rem_sd[QW] != '0);
		negv_c = (QW+1)'(0) - mag_c;
		if (flg_sd[QW].bad || flg_sd[QW].hi) begin
			res_c = ppp_pkg::OUT_MAX;
		end else if (flg_sd[QW].lo) begin
			res_c = ppp_pkg::OUT_MIN;
		end else if (flg_sd[QW].neg) begin
			res_c = QW'(negv_c);
		end else begin
			res_c = q_sd[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[QW+7]) begin
			res_s35 <= res_c;
			sat_s35 <= flg_sd[QW].bad || flg_sd[QW].hi || flg_sd[QW].lo;
		end
	end

	assign res = res_s35;
	assign sat = sat_s35;
endmodule

// ===== hdl/perspective_point_projector.sv =====
// Top level of the perspective point projector: config registers, front pipeline, two axes.
`timescale 1ns / 1ps
// Projects one world point (signed Q8.12 x, y, z) onto the screen and returns
// pixel coordinates in signed Q19.4 plus a saturation flag. Throughput is one point per
// cycle while neither in_stall nor out_stall holds the flow; each point passes the
// three-stage split multipliers and then the 24-stage restoring divider (one quotient
// bit per stage). The pipeline collapses bubbles, so a new point is still taken while a
// finished result waits on out_stall as long as any stage is empty. Constants that
// depend only on the config registers (dot products of the view and screen vectors,
// scaled by the image size) are precomputed in a separate path; after reset and after
// every config write, in_stall stays high while those values settle.
module perspective_point_projector #(
	parameter int OUT_FRAC_BITS = ppp_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [ppp_pkg::CW-1:0]     point_x,
	input  logic signed [ppp_pkg::CW-1:0]     point_y,
	input  logic signed [ppp_pkg::CW-1:0]     point_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ppp_pkg::QW-1:0]     screen_x,
	output logic signed [ppp_pkg::QW-1:0]     screen_y,
	output logic                              saturated,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ppp_pkg::IDXW-1:0]          cfg_index,
	input  logic [ppp_pkg::VW-1:0]            cfg_data
);
	localparam int CW = ppp_pkg::CW;
	localparam int VW = ppp_pkg::VW;
	localparam int DW = ppp_pkg::DW;
	localparam int PRW = ppp_pkg::PRW;
	localparam int SUMW = ppp_pkg::SUMW;
	localparam int UW = ppp_pkg::UW;
	localparam int AAW = ppp_pkg::AAW;
	localparam int SQW = ppp_pkg::SQW;
	localparam int TW = ppp_pkg::TW;
	localparam int SZW = ppp_pkg::SZW;
	localparam int QW = ppp_pkg::QW;
	localparam int SETW = ppp_pkg::SETW;
	localparam int KW = SZW + OUT_FRAC_BITS + 1;   // image size in output units, signed
	localparam int PW = KW + TW + 1;
	localparam int NST = QW + 11;                   // pipeline stages, output register last

	// config registers
	logic [VW-1:0] cam_q, view_q, hvec_q, vvec_q;
	logic [SZW-1:0] wid_q, hgt_q;
	logic [SETW-1:0] settle_q;

	// config-derived constants
	logic signed [AAW-1:0] aa_q [3], ah_q [3], hh_q [3], av_q [3], vv_q [3];
	logic signed [SQW-1:0] num_q, ssh_q, ash_q, ssv_q, asv_q;
	logic signed [KW-1:0] kw_q, kh_q;
	logic signed [TW-1:0] th_q, tv_q;
	logic signed [KW+TW-1:0] kth, ktv;
	logic signed [KW+SQW-1:0] knw, knh;
	logic signed [PW-1:0] ph_q, pv_q, knw_q, knh_q;

	// item pipeline
	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;
	logic signed [CW-1:0] pnt [3];
	logic signed [DW-1:0] d_s1 [3];
	logic signed [PRW-1:0] pda_s2 [3], pdh_s2 [3], pdv_s2 [3];
	logic signed [SUMW-1:0] den_c, sh_c, sv_c;
	logic signed [SUMW-1:0] den_s3;
	logic signed [UW-1:0] uh_s3, uv_s3;
	logic badh_s3, badv_s3;
	logic sath, satv;

	assign cfg_ready = 1'b1;

	// register writes; codes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q <= ppp_pkg::CAM_RST;
			view_q <= ppp_pkg::VIEW_RST;
			hvec_q <= ppp_pkg::HVEC_RST;
			vvec_q <= ppp_pkg::VVEC_RST;
			wid_q <= ppp_pkg::WIDTH_RST;
			hgt_q <= ppp_pkg::HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ppp_pkg::cfg_reg_t'(cfg_index))
				ppp_pkg::REG_CAMERA: cam_q <= cfg_data;
				ppp_pkg::REG_VIEW: view_q <= cfg_data;
				ppp_pkg::REG_HVEC: hvec_q <= cfg_data;
				ppp_pkg::REG_VVEC: vvec_q <= cfg_data;
				ppp_pkg::REG_WIDTH: wid_q <= cfg_data[SZW-1:0];
				ppp_pkg::REG_HEIGHT: hgt_q <= cfg_data[SZW-1:0];
				default: ;
			endcase
		end
	end

	// hold input off while derived constants catch up with a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETW'(ppp_pkg::CFG_SETTLE);
		end else if (cfg_valid && cfg_ready) begin
			settle_q <= SETW'(ppp_pkg::CFG_SETTLE);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// derived constants: per-component products, then dot products and the image-size terms
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			aa_q[i] <= ppp_pkg::comp(view_q, i) * ppp_pkg::comp(view_q, i);
			ah_q[i] <= ppp_pkg::comp(view_q, i) * ppp_pkg::comp(hvec_q, i);
			hh_q[i] <= ppp_pkg::comp(hvec_q, i) * ppp_pkg::comp(hvec_q, i);
			av_q[i] <= ppp_pkg::comp(view_q, i) * ppp_pkg::comp(vvec_q, i);
			vv_q[i] <= ppp_pkg::comp(vvec_q, i) * ppp_pkg::comp(vvec_q, i);
		end
		num_q <= SQW'(aa_q[0]) + SQW'(aa_q[1]) + SQW'(aa_q[2]);
		ssh_q <= SQW'(hh_q[0]) + SQW'(hh_q[1]) + SQW'(hh_q[2]);
		ash_q <= SQW'(ah_q[0]) + SQW'(ah_q[1]) + SQW'(ah_q[2]);
		ssv_q <= SQW'(vv_q[0]) + SQW'(vv_q[1]) + SQW'(vv_q[2]);
		asv_q <= SQW'(av_q[0]) + SQW'(av_q[1]) + SQW'(av_q[2]);
		kw_q <= KW'({wid_q, {OUT_FRAC_BITS{1'b0}}});
		kh_q <= KW'({hgt_q, {OUT_FRAC_BITS{1'b0}}});
		// the vertical axis is flipped
		th_q <= TW'(ssh_q) - TW'(ash_q);
		tv_q <= TW'(ssv_q) + TW'(asv_q);
		ph_q <= PW'(kth) + PW'(ssh_q);
		pv_q <= PW'(ktv) + PW'(ssv_q);
		knw_q <= PW'(knw);
		knh_q <= PW'(knh);
	end

	ppp_mul #(.AW(KW), .BW(TW)) u_mul_kth (
		.clk(clk), .adv(3'b111), .a(kw_q), .b(th_q), .p(kth)
	);
	ppp_mul #(.AW(KW), .BW(TW)) u_mul_ktv (
		.clk(clk), .adv(3'b111), .a(kh_q), .b(tv_q), .p(ktv)
	);
	ppp_mul #(.AW(KW), .BW(SQW)) u_mul_knw (
		.clk(clk), .adv(3'b111), .a(kw_q), .b(num_q), .p(knw)
	);
	ppp_mul #(.AW(KW), .BW(SQW)) u_mul_knh (
		.clk(clk), .adv(3'b111), .a(kh_q), .b(num_q), .p(knh)
	);

	// a stage advances when it or any stage after it has a hole,
	// or when the output is being taken
	for (genvar k = 0; k < NST; k++) begin : g_adv
		assign adv[k] = !out_stall || !(&vld_q[NST-1:k]);
	end

	assign in_stall = !adv[0] || (settle_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid && !in_stall;
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign pnt[0] = point_x;
	assign pnt[1] = point_y;
	assign pnt[2] = point_z;

	// offset from the camera
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DW'(pnt[i]) - DW'(ppp_pkg::comp(cam_q, i));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < 3; i++) begin
				pda_s2[i] <= ppp_pkg::comp(view_q, i) * d_s1[i];
				pdh_s2[i] <= ppp_pkg::comp(hvec_q, i) * d_s1[i];
				pdv_s2[i] <= ppp_pkg::comp(vvec_q, i) * d_s1[i];
			end
		end
	end

	always_comb begin
		den_c = SUMW'(pda_s2[0]) + SUMW'(pda_s2[1]) + SUMW'(pda_s2[2]);
		sh_c = SUMW'(pdh_s2[0]) + SUMW'(pdh_s2[1]) + SUMW'(pdh_s2[2]);
		sv_c = SUMW'(pdv_s2[0]) + SUMW'(pdv_s2[1]) + SUMW'(pdv_s2[2]);
	end

	// zero view dot or zero screen vector length pins the axis at full scale
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			den_s3 <= den_c;
			uh_s3 <= UW'(sh_c);
			uv_s3 <= -UW'(sv_c);
			badh_s3 <= (den_c == '0) || (ssh_q == '0);
			badv_s3 <= (den_c == '0) || (ssv_q == '0);
		end
	end

	ppp_axis #(.PW(PW)) u_axis_h (
		.clk(clk), .adv(adv[NST-1:3]), .den(den_s3), .u(uh_s3), .bad(badh_s3),
		.pvec(ph_q), .kn(knw_q), .ss(ssh_q), .res(screen_x), .sat(sath)
	);
	ppp_axis #(.PW(PW)) u_axis_v (
		.clk(clk), .adv(adv[NST-1:3]), .den(den_s3), .u(uv_s3), .bad(badv_s3),
		.pvec(pv_q), .kn(knh_q), .ss(ssv_q), .res(screen_y), .sat(satv)
	);

	assign saturated = sath || satv;
	assign out_valid = vld_q[NST-1];
endmodule
